/* src/swu_pkg.sv */
// Package for the single-wire half-duplex UART unit.
// Holds the transfer payload types, the mode encoding and bit-timing constants.
// No dependencies.
`timescale 1ns / 1ps

package swu_pkg;

   localparam int unsigned BIT_TICKS_WIDTH = 12;
   localparam int unsigned TICK_WIDTH = 16;
   localparam int unsigned BIT_INDEX_WIDTH = 4;

   localparam logic [BIT_TICKS_WIDTH-1:0] BIT_TICKS_RESET = 12'd52;
   localparam logic [BIT_TICKS_WIDTH-1:0] BIT_TICKS_MIN = 12'd4;

   // Frame positions: start bit, data bits one to eight, stop bit, end of frame.
   localparam logic [BIT_INDEX_WIDTH-1:0] BIT_START = 4'd0;
   localparam logic [BIT_INDEX_WIDTH-1:0] BIT_LAST_DATA = 4'd8;
   localparam logic [BIT_INDEX_WIDTH-1:0] BIT_STOP = 4'd9;
   localparam logic [BIT_INDEX_WIDTH-1:0] BIT_FRAME_END = 4'd10;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_RX   = 3'b010,
      MODE_TX   = 3'b100
   } mode_type;

   typedef struct packed {
      logic       line_level;
      logic       send_valid;
      logic [7:0] send_byte;
   } req_type;

   typedef struct packed {
      logic       line_drive_level;
      logic       drive_enable;
      logic       send_taken;
      logic       recv_valid;
      logic [7:0] recv_byte;
      logic       frame_error;
   } rsp_type;

endpackage

/* src/swu_core.sv */
// Per-tick UART engine: bit-time register, frame state and the one-tick step logic.
// Depends on swu_pkg.
`timescale 1ns / 1ps

module swu_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [11:0]             csr_write_data,
   input  logic                    step,
   input  swu_pkg::req_type        req,
   output swu_pkg::rsp_type        rsp
);
   import swu_pkg::*;

   logic [BIT_TICKS_WIDTH-1:0] bit_ticks_ff;
   mode_type                   mode_ff, mode_in;
   logic [TICK_WIDTH-1:0]      tick_ff, tick_in;
   logic [TICK_WIDTH-1:0]      next_ff, next_in;
   logic [BIT_INDEX_WIDTH-1:0] bit_ff, bit_in;
   logic [7:0]                 shift_ff, shift_in;
   logic                       drive_ff, drive_in;

   logic [BIT_TICKS_WIDTH-1:0] bt;
   logic [BIT_TICKS_WIDTH-2:0] half;
   logic [TICK_WIDTH-1:0]      bt_wide;
   logic [TICK_WIDTH-1:0]      stop_tick;
   logic                       taken, rv, fe;
   logic [7:0]                 rb;

   assign bt = (bit_ticks_ff < BIT_TICKS_MIN) ? BIT_TICKS_MIN : bit_ticks_ff;
   assign half = bt[BIT_TICKS_WIDTH-1:1];
   assign bt_wide = {4'd0, bt};
   // Nine and a half bit times: 8*bt + bt + bt/2.
   assign stop_tick = {1'b0, bt, 3'b000} + bt_wide + {5'd0, half};

   always_comb begin
      logic [BIT_INDEX_WIDTH-1:0] data_pos;
      mode_in  = mode_ff;
      tick_in  = tick_ff;
      next_in  = next_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      drive_in = drive_ff;
      taken    = 1'b0;
      rv       = 1'b0;
      rb       = 8'd0;
      fe       = 1'b0;
      data_pos = bit_ff - 4'd1;

      case (mode_ff)
         MODE_TX: begin
            if (tick_ff >= bt_wide) begin
               tick_in = '0;
               bit_in = bit_ff + 4'd1;
               data_pos = bit_ff;
               if (bit_in >= BIT_FRAME_END) begin
                  if (req.send_valid) begin
                     mode_in  = MODE_TX;
                     shift_in = req.send_byte;
                     bit_in   = BIT_START;
                     tick_in  = 16'd1;
                     drive_in = 1'b0;
                     taken    = 1'b1;
                  end else begin
                     mode_in  = MODE_IDLE;
                     bit_in   = BIT_START;
                     drive_in = 1'b1;
                  end
               end else if (bit_in == BIT_STOP || bit_in == BIT_START) begin
                  drive_in = 1'b1;
               end else begin
                  drive_in = shift_ff[data_pos[2:0]];
               end
            end
            if (mode_in == MODE_TX && !taken) begin
               tick_in = tick_in + 16'd1;
            end
         end
         MODE_RX: begin
            tick_in = tick_ff + 16'd1;
            if (tick_in >= next_ff) begin
               if (bit_ff == BIT_START) begin
                  if (req.line_level) begin
                     fe = 1'b1;
                     mode_in = MODE_IDLE;
                  end else begin
                     bit_in = 4'd1;
                     next_in = next_ff + bt_wide;
                  end
               end else if (bit_ff <= BIT_LAST_DATA) begin
                  shift_in[data_pos[2:0]] = shift_ff[data_pos[2:0]] | req.line_level;
                  if (bit_ff == BIT_LAST_DATA) begin
                     bit_in = BIT_STOP;
                     next_in = stop_tick;
                  end else begin
                     bit_in = bit_ff + 4'd1;
                     next_in = next_ff + bt_wide;
                  end
               end else begin
                  if (req.line_level) begin
                     rv = 1'b1;
                     rb = shift_ff;
                  end else begin
                     fe = 1'b1;
                  end
                  mode_in = MODE_IDLE;
               end
               if (mode_in == MODE_IDLE) begin
                  bit_in = BIT_START;
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      // Idle rules, also applied on the tick an activity ends.
      if (mode_in == MODE_IDLE && !taken) begin
         if (!req.line_level) begin
            mode_in  = MODE_RX;
            tick_in  = '0;
            next_in  = {5'd0, half} + 16'd1;
            bit_in   = BIT_START;
            shift_in = 8'd0;
         end else if (req.send_valid) begin
            mode_in  = MODE_TX;
            shift_in = req.send_byte;
            bit_in   = BIT_START;
            tick_in  = 16'd1;
            drive_in = 1'b0;
            taken    = 1'b1;
         end
      end

      rsp.line_drive_level = drive_in;
      rsp.drive_enable     = (mode_in == MODE_TX);
      rsp.send_taken       = taken;
      rsp.recv_valid       = rv;
      rsp.recv_byte        = rb;
      rsp.frame_error      = fe;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BIT_TICKS_RESET;
         mode_ff      <= MODE_IDLE;
         tick_ff      <= '0;
         next_ff      <= '0;
         bit_ff       <= BIT_START;
         shift_ff     <= 8'd0;
         drive_ff     <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            bit_ticks_ff <= csr_write_data;
         end
         if (step) begin
            mode_ff  <= mode_in;
            tick_ff  <= tick_in;
            next_ff  <= next_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            drive_ff <= drive_in;
         end
      end
   end

   // A frame ends either good or bad, never both.
   assert property (@(posedge clock) disable iff (reset)
      step |-> !(rsp.recv_valid && rsp.frame_error))
      else $error("recv_valid and frame_error raised together");

   // Taking a byte starts a start bit with the drive on.
   assert property (@(posedge clock) disable iff (reset)
      (step && rsp.send_taken) |-> (rsp.drive_enable && !rsp.line_drive_level))
      else $error("send_taken without a low driven start bit");

   // The wire is released high whenever the drive is off.
   assert property (@(posedge clock) disable iff (reset)
      (step && !rsp.drive_enable) |-> rsp.line_drive_level)
      else $error("released wire with low drive level");

   // The received byte field reads zero unless a good frame ends on this tick.
   assert property (@(posedge clock) disable iff (reset)
      (step && !rsp.recv_valid) |-> (rsp.recv_byte == 8'd0))
      else $error("recv_byte nonzero without recv_valid");

endmodule

/* src/swu_out_buf.sv */
// Two-entry result buffer (output register plus skid register) for the rsp channel.
// Depends on swu_pkg.
`timescale 1ns / 1ps

module swu_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  swu_pkg::rsp_type  push_data,
   output logic              can_push,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output swu_pkg::rsp_type  rsp_payload
);
   import swu_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop = main_valid_ff && rsp_ready;
   assign can_push = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_payload = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in = main_ff;
      skid_in = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // The skid entry is only used behind a held output entry.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid with empty output entry");

   // Nothing is pushed while the skid entry is occupied.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("push into a full buffer");

   // A taken output with a waiting skid entry refills the output at once.
   assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved forward");

endmodule

/* src/single_wire_half_duplex_uart_unit.sv */
// Top level of the single-wire half-duplex UART unit.
// Depends on swu_pkg, swu_core and swu_out_buf.
`timescale 1ns / 1ps

// Usage
// Each transfer on the req channel is one timer tick: the sampled wire level
// and an optional byte offered for sending. Each tick yields exactly one transfer
// on the rsp channel: the drive level and drive enable for the wire, whether the
// offered byte was taken, and a received byte or a framing error when a frame
// ends on that tick.
// The bit length in ticks is set through the csr port (write enable plus data,
// no read-back); values below four act as four. Write it only while no frame
// is in progress.
// The result of an accepted tick is registered into the output register, or
// into the skid register while the output register is held. Throughput is one
// tick per cycle while req_ready is high, set by the single pass of step logic
// between the state registers and the output register.
// When the rsp side stalls, a skid register holds one more result, so req_ready
// stays high until two results wait; it then drops until the output is taken.
// Reset clears the frame state to idle with the wire released high, empties the
// result buffer and loads the default bit length of 52 ticks.
module single_wire_half_duplex_uart_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  swu_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output swu_pkg::rsp_type  rsp_payload,
   input  logic              csr_write_enable,
   input  logic [11:0]       csr_write_data
);
   import swu_pkg::*;

   logic    step;
   rsp_type step_result;

   // A tick is stepped exactly when its transfer completes.
   assign step = req_valid && req_ready;

   swu_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .req              (req_payload),
      .rsp              (step_result)
   );

   swu_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (step),
      .push_data   (step_result),
      .can_push    (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* bench/tb.sv */
// Self-checking bench for single_wire_half_duplex_uart_unit: a tick-level predictor of the
// shared-wire UART, a directed table of frames and random frame traffic at several bit lengths.
// Depends on swu_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb;
   import swu_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either channel
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_TICKS = 20;

   // Output values that can be read straight off the frame rules.
   localparam rsp_type NO_EXP = '0;
   localparam rsp_type IDLE_OUT = '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
   localparam rsp_type TAKEN_OUT = '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
   localparam rsp_type FRAME_ERR_OUT = '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1};

   typedef enum logic [1:0] {ROW_HOLD, ROW_FRAME, ROW_CONFIG} row_kind_type;

   // A HOLD row repeats one tick count times. A FRAME row plays a whole 8N1 frame of data
   // on the wire, with line as the stop level and offer held during the frame. A CONFIG
   // row waits for idle and then sets the bit length to count.
   typedef struct packed {
      row_kind_type kind;
      logic         line;
      logic         offer;
      logic [7:0]   data;
      int           count;
      logic         typed;
      rsp_type      exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_payload;
   logic csr_write_enable;
   logic [11:0] csr_write_data;

   // Predicted state of the unit, advanced once per accepted tick.
   mode_type p_mode;
   logic [15:0] p_ticks;
   logic [15:0] p_next;
   logic [3:0] p_bit;
   logic [7:0] p_shift;
   logic p_drive;
   logic [11:0] p_bit_ticks;

   rsp_type pending_outputs [$];

   int unsigned mismatch_count = 0;
   int unsigned ticks_sent = 0;
   int unsigned bytes_received = 0;
   int unsigned framing_errors = 0;
   int unsigned sends_started = 0;
   int unsigned quiet_cycles = 0;

   // Handshake shaping shared by the stimulus and the receiver process.
   bit calm = 1'b0;
   bit hold_off_req = 1'b0;
   bit hold_off_done = 1'b0;
   int hold_off_left = 0;

   stim_row_type directed_rows [16] = '{
      // Idle outputs straight after reset.
      '{ROW_HOLD, 1'b1, 1'b0, 8'h00, 3, 1'b1, IDLE_OUT},
      // False start at the reset bit length: one low tick, then high at the start sample.
      '{ROW_HOLD, 1'b0, 1'b0, 8'h00, 1, 1'b1, IDLE_OUT},
      '{ROW_HOLD, 1'b1, 1'b0, 8'h00, 26, 1'b0, NO_EXP},
      '{ROW_HOLD, 1'b1, 1'b0, 8'h00, 1, 1'b1, FRAME_ERR_OUT},
      // The rest of the table runs at the shortest bit length so that frames stay short.
      '{ROW_CONFIG, 1'b1, 1'b0, 8'h00, 4, 1'b0, NO_EXP},
      // An offer on a high, idle wire is taken and the start bit goes out at once.
      '{ROW_HOLD, 1'b1, 1'b1, 8'hFF, 1, 1'b1, TAKEN_OUT},
      // The wire level is ignored while transmitting, and a byte still offered at the end
      // of the stop bit keeps the drive on.
      '{ROW_HOLD, 1'b0, 1'b1, 8'h5A, 10, 1'b0, NO_EXP},
      '{ROW_HOLD, 1'b1, 1'b1, 8'h5A, 30, 1'b0, NO_EXP},
      '{ROW_HOLD, 1'b1, 1'b0, 8'h00, 42, 1'b0, NO_EXP},
      // False start at the shortest bit length.
      '{ROW_HOLD, 1'b0, 1'b0, 8'h00, 1, 1'b1, IDLE_OUT},
      '{ROW_HOLD, 1'b1, 1'b0, 8'h00, 2, 1'b0, NO_EXP},
      '{ROW_HOLD, 1'b1, 1'b0, 8'h00, 1, 1'b1, FRAME_ERR_OUT},
      // Reception wins over a pending offer, which is then taken as the frame ends.
      '{ROW_FRAME, 1'b1, 1'b1, 8'hA5, 1, 1'b0, NO_EXP},
      '{ROW_HOLD, 1'b1, 1'b0, 8'h00, 42, 1'b0, NO_EXP},
      // Low stop bit: framing error, and the low wire starts a new reception right away.
      '{ROW_FRAME, 1'b0, 1'b0, 8'h3C, 1, 1'b0, NO_EXP},
      '{ROW_HOLD, 1'b1, 1'b0, 8'h00, 8, 1'b0, NO_EXP}
   };

   single_wire_half_duplex_uart_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // Bit length in use: anything below the minimum acts as the minimum.
   function automatic int bit_len();
      return (p_bit_ticks < BIT_TICKS_MIN) ? int'(BIT_TICKS_MIN) : int'(p_bit_ticks);
   endfunction

   function automatic void load_send_byte(input logic [7:0] data);
      p_mode = MODE_TX;
      p_shift = data;
      p_bit = BIT_START;
      p_ticks = 16'd1;
      p_drive = 1'b0;
   endfunction

   // Advances the predicted state by one tick and returns the outputs for that tick.
   function automatic rsp_type predict_tick_outputs(input req_type r);
      rsp_type o;
      logic taken;
      logic [15:0] bt16;
      logic [15:0] half16;
      o = '0;
      taken = 1'b0;
      bt16 = 16'(bit_len());
      half16 = bt16 >> 1;
      case (p_mode)
         MODE_TX: begin
            if (p_ticks >= bt16) begin
               p_ticks = 16'd0;
               p_bit = p_bit + 4'd1;
               if (p_bit >= BIT_FRAME_END) begin
                  if (r.send_valid) begin
                     load_send_byte(r.send_byte);
                     taken = 1'b1;
                  end else begin
                     p_mode = MODE_IDLE;
                     p_bit = BIT_START;
                     p_drive = 1'b1;
                  end
               end else if (p_bit == BIT_STOP || p_bit == BIT_START) begin
                  p_drive = 1'b1;
               end else begin
                  p_drive = p_shift[p_bit - 4'd1];
               end
            end
            if (p_mode == MODE_TX && !taken) p_ticks = p_ticks + 16'd1;
         end
         MODE_RX: begin
            p_ticks = p_ticks + 16'd1;
            if (p_ticks >= p_next) begin
               if (p_bit == BIT_START) begin
                  if (r.line_level) begin
                     o.frame_error = 1'b1;
                     p_mode = MODE_IDLE;
                  end else begin
                     p_bit = 4'd1;
                     p_next = p_next + bt16;
                  end
               end else if (p_bit <= BIT_LAST_DATA) begin
                  if (r.line_level) p_shift[p_bit - 4'd1] = 1'b1;
                  if (p_bit == BIT_LAST_DATA) begin
                     // The stop sample sits at nine and a half bits from the first low tick.
                     p_bit = BIT_STOP;
                     p_next = 16'(bt16 * 16'd9 + half16);
                  end else begin
                     p_bit = p_bit + 4'd1;
                     p_next = p_next + bt16;
                  end
               end else begin
                  if (r.line_level) begin
                     o.recv_valid = 1'b1;
                     o.recv_byte = p_shift;
                  end else begin
                     o.frame_error = 1'b1;
                  end
                  p_mode = MODE_IDLE;
               end
               if (p_mode == MODE_IDLE) p_bit = BIT_START;
            end
         end
         default: ;
      endcase
      // Idle rules, applied also on the tick an activity ends.
      if (p_mode == MODE_IDLE && !taken) begin
         if (!r.line_level) begin
            p_mode = MODE_RX;
            p_ticks = 16'd0;
            p_next = half16 + 16'd1;
            p_bit = BIT_START;
            p_shift = 8'h00;
         end else if (r.send_valid) begin
            load_send_byte(r.send_byte);
            taken = 1'b1;
         end
      end
      o.line_drive_level = p_drive;
      o.drive_enable = (p_mode == MODE_TX);
      o.send_taken = taken;
      return o;
   endfunction

   // Offers one tick on the req channel, with an occasional idle cycle before it, and
   // records the expected outputs once the transfer happens. Called at a rising edge.
   task automatic send_tick(input logic line, input logic offer, input logic [7:0] data,
                            input logic typed, input rsp_type typed_exp);
      req_type item;
      rsp_type predicted;
      item.line_level = line;
      item.send_valid = offer;
      item.send_byte = data;
      if (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_tick_outputs(item);
      pending_outputs.push_back(typed ? typed_exp : predicted);
      ticks_sent++;
   endtask

   // Plays a complete 8N1 frame on the wire, one bit length per bit, LSB first.
   task automatic play_frame(input logic [7:0] data, input logic stop_level,
                             input int offer_pct);
      logic level;
      int len;
      len = bit_len();
      for (int k = 0; k < 10; k++) begin
         if (k == 0) level = 1'b0;
         else if (k == 9) level = stop_level;
         else level = data[k-1];
         repeat (len) send_tick(level, ($urandom_range(99) < offer_pct), 8'($urandom),
                                1'b0, NO_EXP);
      end
   endtask

   // Offers one byte, then keeps ticking for about one frame with noise on the wire, which
   // the unit must ignore. With chain set, further bytes stay offered back to back.
   task automatic play_send(input bit chain);
      send_tick(1'b1, 1'b1, 8'($urandom), 1'b0, NO_EXP);
      repeat (10 * bit_len() + $urandom_range(0, 3))
         send_tick(1'($urandom), chain, 8'($urandom), 1'b0, NO_EXP);
   endtask

   // Brings the unit back to idle with a high wire and waits until every result is in,
   // so that the bit length can be changed.
   task automatic settle_idle();
      while (p_mode != MODE_IDLE) send_tick(1'b1, 1'b0, 8'h00, 1'b0, NO_EXP);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Sets a new bit length once nothing is in flight.
   task automatic write_bit_ticks(input logic [11:0] value);
      settle_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      p_bit_ticks = value;
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // Receiver: random stalls, a calm stretch with none, and one long hold-off while the
   // sender keeps going, so that the unit's buffer fills and req_ready drops.
   always @(posedge clock) begin
      if (hold_off_req && !hold_off_done) begin
         hold_off_done = 1'b1;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 8);
      end
   end

   // Every rsp transfer is matched against the oldest expected tick outputs.
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_payload);
         end else begin
            want = pending_outputs.pop_front();
            check_field("line_drive_level", want.line_drive_level,
                        rsp_payload.line_drive_level);
            check_field("drive_enable", want.drive_enable, rsp_payload.drive_enable);
            check_field("send_taken", want.send_taken, rsp_payload.send_taken);
            check_field("recv_valid", want.recv_valid, rsp_payload.recv_valid);
            check_field("recv_byte", want.recv_byte, rsp_payload.recv_byte);
            check_field("frame_error", want.frame_error, rsp_payload.frame_error);
            if (want.recv_valid) bytes_received++;
            if (want.frame_error) framing_errors++;
            if (want.send_taken) sends_started++;
         end
      end
   end

   // Watchdog: a long run of cycles without any transfer means the unit has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      stim_row_type row;
      logic [11:0] bit_settings [4];
      int unsigned phase_start;
      int pick;
      int len;

      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = BIT_TICKS_RESET;

      p_mode = MODE_IDLE;
      p_ticks = '0;
      p_next = '0;
      p_bit = BIT_START;
      p_shift = '0;
      p_drive = 1'b1;
      p_bit_ticks = BIT_TICKS_RESET;

      // Bit lengths for the random phases: zero and three, both below the minimum, a small
      // odd value and one random pick.
      bit_settings = '{12'd0, 12'd3, 12'd5, 12'd0};
      bit_settings[3] = 12'($urandom_range(6, 9));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table, starting at the reset bit length.
      for (int i = 0; i < $size(directed_rows); i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_FRAME)
            play_frame(row.data, row.line, row.offer ? 100 : 0);
         else if (row.kind == ROW_CONFIG)
            write_bit_ticks(12'(row.count));
         else
            repeat (row.count) send_tick(row.line, row.offer, row.data, row.typed, row.exp);
      end

      for (int p = 0; p < $size(bit_settings); p++) begin
         write_bit_ticks(bit_settings[p]);

         // The first phase runs without any idling on either side; the next one carries
         // the long receiver hold-off.
         calm = (p == 0);
         if (p == 1) hold_off_req = 1'b1;

         phase_start = ticks_sent;
         while (ticks_sent - phase_start < PHASE_TICKS) begin
            len = bit_len();
            pick = $urandom_range(99);
            if (pick < 50) begin
               play_frame(8'($urandom), 1'b1, ($urandom_range(1) == 1) ? 30 : 0);
            end else if (pick < 70) begin
               play_send($urandom_range(2) == 0);
            end else if (pick < 80) begin
               play_frame(8'($urandom), 1'b0, 0);
            end else if (pick < 90) begin
               // Glitch shorter than the start sample point.
               repeat ($urandom_range(1, len / 2))
                  send_tick(1'b0, 1'b0, 8'h00, 1'b0, NO_EXP);
               repeat (len + 2) send_tick(1'b1, 1'b0, 8'h00, 1'b0, NO_EXP);
            end else begin
               repeat ($urandom_range(1, 20))
                  send_tick(1'($urandom), ($urandom_range(99) < 20), 8'($urandom),
                            1'b0, NO_EXP);
            end
            // Short high gap between segments, sometimes with an offer.
            repeat ($urandom_range(0, 3))
               send_tick(1'b1, ($urandom_range(9) == 0), 8'($urandom), 1'b0, NO_EXP);
         end
      end

      settle_idle();
      calm = 1'b0;
      repeat (8) @(posedge clock);

      $display("summary: %0d ticks checked, %0d bytes received, %0d framing errors, %0d sends",
               ticks_sent, bytes_received, framing_errors, sends_started);
      $display("summary: table at bit lengths 52 and 4, random traffic at 0, 3, 5 and %0d, %s",
               bit_settings[3], "one long output stall");
      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
